// ----- sv/ytw_pkg.sv -----
// ----------------------------------------------------------------------------
// ytw_pkg
// Shared constants, register indexes and the arctangent table of the
// Y-axis twist deformer.
// ----------------------------------------------------------------------------
package ytw_pkg;

  // default configuration of the top level
  localparam int COORD_WIDTH_DEF   = 32;
  localparam int CORDIC_STAGES_DEF = 24;

  // register map
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_TWIST_RATE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ENVELOPE_GAIN = 1'b1;

  // register widths and reset values
  localparam int RATE_W = 32;
  localparam int ENV_W  = 17;
  localparam logic [ENV_W-1:0]  ENV_ONE    = 17'd65536;
  localparam logic [RATE_W-1:0] RATE_RESET = '0;

  // fixed-point constants
  localparam int KT_W = 46;  // turns per unit, Q.40
  localparam logic [30:0] INV_TWO_PI_Q32    = 31'd683565276;
  localparam logic [33:0] CORDIC_INV_GAIN_Q30 = 34'd652032874;
  localparam int CORDIC_W = 34;  // cordic datapath width
  localparam int PHASE_W  = 32;

  // fraction bits of cos and sin
  function automatic int trig_frac(input int cw);
    trig_frac = ((61 - cw) < 30) ? (61 - cw) : 30;
  endfunction

  // arctangent of 2^-i in binary-angle units (2^32 is one turn)
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    case (idx)
      5'd0:  atan_turn = 32'h20000000;
      5'd1:  atan_turn = 32'h12E4051E;
      5'd2:  atan_turn = 32'h09FB385B;
      5'd3:  atan_turn = 32'h051111D4;
      5'd4:  atan_turn = 32'h028B0D43;
      5'd5:  atan_turn = 32'h0145D7E1;
      5'd6:  atan_turn = 32'h00A2F61E;
      5'd7:  atan_turn = 32'h00517C55;
      5'd8:  atan_turn = 32'h0028BE53;
      5'd9:  atan_turn = 32'h00145F2F;
      5'd10: atan_turn = 32'h000A2F98;
      5'd11: atan_turn = 32'h000517CC;
      5'd12: atan_turn = 32'h00028BE6;
      5'd13: atan_turn = 32'h000145F3;
      5'd14: atan_turn = 32'h0000A2F9;
      5'd15: atan_turn = 32'h0000517C;
      5'd16: atan_turn = 32'h000028BE;
      5'd17: atan_turn = 32'h0000145F;
      5'd18: atan_turn = 32'h00000A2F;
      5'd19: atan_turn = 32'h00000517;
      5'd20: atan_turn = 32'h0000028B;
      5'd21: atan_turn = 32'h00000145;
      5'd22: atan_turn = 32'h000000A2;
      5'd23: atan_turn = 32'h00000051;
      5'd24: atan_turn = 32'h00000028;
      5'd25: atan_turn = 32'h00000014;
      5'd26: atan_turn = 32'h0000000A;
      5'd27: atan_turn = 32'h00000005;
      5'd28: atan_turn = 32'h00000002;
      5'd29: atan_turn = 32'h00000001;
      default: atan_turn = 32'h00000000;
    endcase
  endfunction

endpackage

// ----- sv/ytw_phase.sv -----
// ----------------------------------------------------------------------------
// ytw_phase
// Four-stage pipeline from the vertex height to the twist angle as a
// 32-bit binary angle.
// ----------------------------------------------------------------------------
module ytw_phase #(
  parameter int COORD_WIDTH = ytw_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [3*COORD_WIDTH-1:0]            vtx_i,    // x, y, z from lsb
  input  logic [ytw_pkg::RATE_W-1:0]          rate_i,
  input  logic [ytw_pkg::ENV_W-1:0]           env_i,
  output logic                                valid_o,
  output logic [3*COORD_WIDTH-1:0]            vtx_o,
  output logic [ytw_pkg::PHASE_W-1:0]         phase_o
);
  import ytw_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int AF   = CW / 2;
  localparam int H    = AF;
  localparam int P0_W = KT_W + H + 1;
  localparam int P1_W = KT_W + CW - H;
  localparam int FW   = KT_W + CW + 1;

  logic [3:0]        v_q;
  logic [3*CW-1:0]   vtx_q [4];
  logic [ENV_W-1:0]  env_sat;
  logic signed [RATE_W+ENV_W:0] ke_prod;
  logic signed [31:0]           k_q;
  logic signed [62:0]           kt_prod;
  logic signed [KT_W-1:0]       kt_q;
  logic signed [P0_W-1:0]       p0_d, p0_q;
  logic signed [P1_W-1:0]       p1_d, p1_q;
  logic signed [FW-1:0]         full;
  logic [PHASE_W-1:0]           phase_q;
  logic [CW-1:0]                y_s2;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  // rate times envelope, envelope saturated at one
  assign env_sat = (env_i > ENV_ONE) ? ENV_ONE : env_i;
  assign ke_prod = $signed(rate_i) * $signed({1'b0, env_sat});

  // radians to turns
  assign kt_prod = k_q * $signed({1'b0, INV_TWO_PI_Q32});

  // angle product split over the halves of y
  assign y_s2 = vtx_q[1][2*CW-1:CW];
  assign p0_d = kt_q * $signed({1'b0, y_s2[H-1:0]});
  assign p1_d = kt_q * $signed(y_s2[CW-1:H]);
  assign full = ($signed({{(FW-P1_W){p1_q[P1_W-1]}}, p1_q}) <<< H)
              + $signed({{(FW-P0_W){p0_q[P0_W-1]}}, p0_q});

  // payload stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vtx_q[0] <= vtx_i;
      vtx_q[1] <= vtx_q[0];
      vtx_q[2] <= vtx_q[1];
      vtx_q[3] <= vtx_q[2];
      k_q      <= ke_prod[47:16];
      kt_q     <= kt_prod[61:16];
      p0_q     <= p0_d;
      p1_q     <= p1_d;
      phase_q  <= full[8+AF +: PHASE_W];
    end
  end

  assign valid_o = v_q[3];
  assign vtx_o   = vtx_q[3];
  assign phase_o = phase_q;

endmodule

// ----- sv/ytw_cordic.sv -----
// ----------------------------------------------------------------------------
// ytw_cordic
// Quadrant split followed by one pipelined CORDIC rotation per stage,
// giving cos and sin of the residual angle in Q30.
// ----------------------------------------------------------------------------
module ytw_cordic #(
  parameter int COORD_WIDTH   = ytw_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STAGES = ytw_pkg::CORDIC_STAGES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [3*COORD_WIDTH-1:0]          vtx_i,
  input  logic [ytw_pkg::PHASE_W-1:0]       phase_i,
  output logic                              valid_o,
  output logic [3*COORD_WIDTH-1:0]          vtx_o,
  output logic                              zero_o,
  output logic [1:0]                        quad_o,
  output logic signed [ytw_pkg::CORDIC_W-1:0] cx_o,
  output logic signed [ytw_pkg::CORDIC_W-1:0] cy_o
);
  import ytw_pkg::*;

  localparam int N = CORDIC_STAGES;

  logic [N:0]                    v_q;
  logic [3*COORD_WIDTH-1:0]      vtx_q  [N+1];
  logic                          zero_q [N+1];
  logic [1:0]                    quad_q [N+1];
  logic signed [CORDIC_W-1:0]    cx_q   [N+1];
  logic signed [CORDIC_W-1:0]    cy_q   [N+1];
  logic signed [CORDIC_W-1:0]    r_q    [N+1];
  logic [1:0]                    quad_d;
  logic [PHASE_W-1:0]            resid;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[N-1:0], valid_i};
    end
  end

  // nearest quarter turn and residue
  assign quad_d = 2'(({2'b00, phase_i} + 34'h020000000) >> 30);
  assign resid  = phase_i - {quad_d, 30'd0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vtx_q[0]  <= vtx_i;
      zero_q[0] <= (phase_i == '0);
      quad_q[0] <= quad_d;
      cx_q[0]   <= $signed(CORDIC_INV_GAIN_Q30);
      cy_q[0]   <= '0;
      r_q[0]    <= $signed({{(CORDIC_W-PHASE_W){resid[PHASE_W-1]}}, resid});
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [31:0]                at;
    logic signed [CORDIC_W-1:0] dx, dy;
    assign at = atan_turn(5'(i));
    assign dx = cy_q[i] >>> i;
    assign dy = cx_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        vtx_q[i+1]  <= vtx_q[i];
        zero_q[i+1] <= zero_q[i];
        quad_q[i+1] <= quad_q[i];
        if (!r_q[i][CORDIC_W-1]) begin
          cx_q[i+1] <= cx_q[i] - dx;
          cy_q[i+1] <= cy_q[i] + dy;
          r_q[i+1]  <= r_q[i] - $signed({2'b00, at});
        end else begin
          cx_q[i+1] <= cx_q[i] + dx;
          cy_q[i+1] <= cy_q[i] - dy;
          r_q[i+1]  <= r_q[i] + $signed({2'b00, at});
        end
      end
    end
  end

  assign valid_o = v_q[N];
  assign vtx_o   = vtx_q[N];
  assign zero_o  = zero_q[N];
  assign quad_o  = quad_q[N];
  assign cx_o    = cx_q[N];
  assign cy_o    = cy_q[N];

endmodule

// ----- sv/ytw_rotate.sv -----
// ----------------------------------------------------------------------------
// ytw_rotate
// Quadrant fix-up and rounding of cos and sin, the four products, then
// rounding and saturation of the rotated x and z.
// ----------------------------------------------------------------------------
module ytw_rotate #(
  parameter int COORD_WIDTH = ytw_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [3*COORD_WIDTH-1:0]            vtx_i,
  input  logic                                zero_i,
  input  logic [1:0]                          quad_i,
  input  logic signed [ytw_pkg::CORDIC_W-1:0] cx_i,
  input  logic signed [ytw_pkg::CORDIC_W-1:0] cy_i,
  output logic                                valid_o,
  output logic [3*COORD_WIDTH-1:0]            vtx_o
);
  import ytw_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int TF  = trig_frac(COORD_WIDTH);
  localparam int SH  = 30 - TF;
  localparam int TW  = TF + 2;
  localparam int PW  = CW + TW;
  localparam int SW  = PW + 1;
  localparam logic signed [CORDIC_W-1:0] RND1 =
    (SH > 0) ? CORDIC_W'(64'd1 << (SH > 0 ? SH - 1 : 0)) : '0;
  localparam logic signed [CORDIC_W-1:0] ONE  = CORDIC_W'(64'd1 << TF);
  localparam logic signed [SW-1:0] RND2 = SW'(64'd1 << (TF - 1));
  localparam logic signed [SW-1:0] MAXV = SW'((65'd1 << (CW - 1)) - 65'd1);
  localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);

  logic [2:0]                 v_q;
  logic [3*CW-1:0]            vtx_q [2];
  logic                       zero_q [2];
  logic signed [CORDIC_W-1:0] c_sel, s_sel, c_rnd, s_rnd;
  logic signed [TW-1:0]       c_q, s_q;
  logic signed [PW-1:0]       xc_q, xs_q, zc_q, zs_q;
  logic signed [CW-1:0]       x1, z1;
  logic signed [SW-1:0]       ax, az, rx, rz;
  logic [3*CW-1:0]            out_q;
  logic [CW-1:0]              ox, oz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  // rotate cos and sin by the quadrant
  always_comb begin
    case (quad_i)
      2'd0:    begin c_sel = cx_i;  s_sel = cy_i;  end
      2'd1:    begin c_sel = -cy_i; s_sel = cx_i;  end
      2'd2:    begin c_sel = -cx_i; s_sel = -cy_i; end
      default: begin c_sel = cy_i;  s_sel = -cx_i; end
    endcase
  end

  // round to trig precision and clamp to plus or minus one
  always_comb begin
    c_rnd = (c_sel + RND1) >>> SH;
    s_rnd = (s_sel + RND1) >>> SH;
    if (c_rnd > ONE) c_rnd = ONE;
    if (c_rnd < -ONE) c_rnd = -ONE;
    if (s_rnd > ONE) s_rnd = ONE;
    if (s_rnd < -ONE) s_rnd = -ONE;
  end

  assign x1 = $signed(vtx_q[0][CW-1:0]);
  assign z1 = $signed(vtx_q[0][3*CW-1:2*CW]);

  // combine, round and saturate
  assign ax = $signed({xc_q[PW-1], xc_q}) - $signed({zs_q[PW-1], zs_q});
  assign az = $signed({xs_q[PW-1], xs_q}) + $signed({zc_q[PW-1], zc_q});
  assign rx = (ax + RND2) >>> TF;
  assign rz = (az + RND2) >>> TF;
  assign ox = (rx > MAXV) ? MAXV[CW-1:0] : ((rx < MINV) ? MINV[CW-1:0] : rx[CW-1:0]);
  assign oz = (rz > MAXV) ? MAXV[CW-1:0] : ((rz < MINV) ? MINV[CW-1:0] : rz[CW-1:0]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vtx_q[0]  <= vtx_i;
      zero_q[0] <= zero_i;
      c_q       <= c_rnd[TW-1:0];
      s_q       <= s_rnd[TW-1:0];
      vtx_q[1]  <= vtx_q[0];
      zero_q[1] <= zero_q[0];
      xc_q      <= x1 * c_q;
      xs_q      <= x1 * s_q;
      zc_q      <= z1 * c_q;
      zs_q      <= z1 * s_q;
      if (zero_q[1]) begin
        out_q <= vtx_q[1];
      end else begin
        out_q <= {oz, vtx_q[1][2*CW-1:CW], ox};
      end
    end
  end

  assign valid_o = v_q[2];
  assign vtx_o   = out_q;

endmodule

// ----- sv/y_twist_vertex_deformer_unit.sv -----
// ----------------------------------------------------------------------------
// y_twist_vertex_deformer_unit
// Twists a stream of vertices about the Y axis by twist_rate * y * envelope.
// ----------------------------------------------------------------------------
// One vertex is accepted per clock and one result leaves per clock while
// the skid register is empty. Vertices pass through the angle product, the
// quadrant split, one CORDIC rotation per stage, then rounding, products and
// saturation. A two-entry output (last stage plus skid register) lets one
// more vertex in while a result waits downstream. Configuration registers
// are read as vertices enter, so write them only while the block is idle.
module y_twist_vertex_deformer_unit #(
  parameter int COORD_WIDTH   = ytw_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STAGES = ytw_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [ytw_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [ytw_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  // vertex in
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]  s_axis_tdata,  // in_x, in_y, in_z
  // vertex out
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0]  m_axis_tdata   // out_x, out_y, out_z
);
  import ytw_pkg::*;

  localparam int VW = 3 * COORD_WIDTH;
  localparam int DW = ((3 * COORD_WIDTH + 7) / 8) * 8;

  logic [RATE_W-1:0] rate_q;
  logic [ENV_W-1:0]  env_q;
  logic              en;
  logic              ph_valid, cd_valid, cd_zero, rt_valid;
  logic [VW-1:0]     ph_vtx, cd_vtx, rt_vtx;
  logic [PHASE_W-1:0] ph_phase;
  logic [1:0]        cd_quad;
  logic signed [CORDIC_W-1:0] cd_cx, cd_cy;
  logic              skid_valid_q;
  logic [VW-1:0]     skid_q;
  logic [VW-1:0]     m_vtx;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RATE_RESET;
      env_q  <= ENV_ONE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TWIST_RATE:    rate_q <= cfg_wdata_i[RATE_W-1:0];
        REG_ENVELOPE_GAIN: env_q  <= cfg_wdata_i[ENV_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advances while the skid register is free
  assign en            = !skid_valid_q;
  assign s_axis_tready = en;

  ytw_phase #(.COORD_WIDTH(COORD_WIDTH)) u_phase (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .vtx_i   (s_axis_tdata[VW-1:0]),
    .rate_i  (rate_q),
    .env_i   (env_q),
    .valid_o (ph_valid),
    .vtx_o   (ph_vtx),
    .phase_o (ph_phase)
  );

  ytw_cordic #(.COORD_WIDTH(COORD_WIDTH), .CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ph_valid),
    .vtx_i   (ph_vtx),
    .phase_i (ph_phase),
    .valid_o (cd_valid),
    .vtx_o   (cd_vtx),
    .zero_o  (cd_zero),
    .quad_o  (cd_quad),
    .cx_o    (cd_cx),
    .cy_o    (cd_cy)
  );

  ytw_rotate #(.COORD_WIDTH(COORD_WIDTH)) u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cd_valid),
    .vtx_i   (cd_vtx),
    .zero_i  (cd_zero),
    .quad_i  (cd_quad),
    .cx_i    (cd_cx),
    .cy_i    (cd_cy),
    .valid_o (rt_valid),
    .vtx_o   (rt_vtx)
  );

  // skid register catches the last stage when the sink stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (m_axis_tready) skid_valid_q <= 1'b0;
    end else if (rt_valid && !m_axis_tready) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_valid_q) begin
      skid_q <= rt_vtx;
    end
  end

  // output select
  assign m_axis_tvalid = skid_valid_q || rt_valid;
  assign m_vtx         = skid_valid_q ? skid_q : rt_vtx;
  assign m_axis_tdata  = DW'(m_vtx);

endmodule

// ----- sv/ytw_checker.sv -----
// ----------------------------------------------------------------------------
// ytw_checker
// Port-level checks of the twist deformer stream handshake.
// ----------------------------------------------------------------------------
module ytw_checker #(
  parameter int COORD_WIDTH = ytw_pkg::COORD_WIDTH_DEF
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // input only blocks while a result is waiting
  a_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input blocked with no pending result");

  // blocking starts only after an untaken result
  a_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("input blocked without output stall");

endmodule

bind y_twist_vertex_deformer_unit ytw_checker #(.COORD_WIDTH(COORD_WIDTH)) u_ytw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
